### design/assert_macros.svh
// assertion macros used by the rtl controller plt_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge, off while rst is high
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen at a rising clk edge
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### design/plt_pkg.sv
// types and constants of the polyline length block
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DIFF_BITS  = COORD_BITS;
  localparam int SQ_BITS    = 2 * DIFF_BITS;
  // radicand pairs: two squares sum to one bit more than a square
  localparam int RAD_PAIRS  = DIFF_BITS + 1;
  localparam int RAD_BITS   = 2 * RAD_PAIRS;
  localparam int ROOT_BITS  = RAD_PAIRS + FRAC_BITS;
  localparam int REM_BITS   = ROOT_BITS + 1;
  localparam int SUM_BITS   = 35;
  localparam int CFG_BITS   = 10;
  localparam int PROD_BITS  = SUM_BITS + CFG_BITS;
  localparam int OUT_BITS   = 40;
  localparam int SCALE_DIV  = 50;
  localparam int DREM_BITS  = $clog2(SCALE_DIV);
  // divide by fifty one 8-bit quotient digit at a time
  localparam int DIV_DIGIT  = 8;
  localparam int DIV_DIGITS = (PROD_BITS + DIV_DIGIT - 1) / DIV_DIGIT;
  localparam int DIV_BITS   = DIV_DIGITS * DIV_DIGIT;
  localparam int DV_BITS    = DREM_BITS + DIV_DIGIT;
  // reciprocal is exact for every partial dividend below fifty times 256
  localparam int DIV_SHIFT  = 19;
  localparam int DIV_RECIP  = ((1 << DIV_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;
  localparam int CNT_BITS   = $clog2(ROOT_BITS);
  localparam logic [CFG_BITS-1:0] REPEAT_RESET = CFG_BITS'(1);
  localparam logic [CNT_BITS-1:0] ROOT_LAST    = CNT_BITS'(ROOT_BITS - 1);
  localparam logic [CNT_BITS-1:0] DIV_LAST     = CNT_BITS'(DIV_DIGITS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_ACCUM,
    ST_SCALE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic square;
    logic root_init;
    logic root_step;
    logic accum;
    logic scale;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic out_valid;
    logic out_ready;
  } sts_t;

endpackage

`default_nettype wire

### design/plt_ctrl.sv
// controller state machine of the polyline length block
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module plt_ctrl
  import plt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;
  logic [CNT_BITS-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // iteration counter shared by the root and the divide-by-constant loops
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.root_init || cmd.scale) begin
      cnt <= '0;
    end else if (cmd.root_step || cmd.div_step) begin
      cnt <= cnt + CNT_BITS'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DIFF;
      end
      ST_DIFF: begin
        if (!sts.first) state_next = ST_SQUARE;
        else if (sts.last) state_next = ST_SCALE;
        else state_next = ST_IDLE;
      end
      ST_SQUARE:    state_next = ST_ROOT_INIT;
      ST_ROOT_INIT: state_next = ST_ROOT;
      ST_ROOT: begin
        if (cnt == ROOT_LAST) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        state_next = sts.last ? ST_SCALE : ST_IDLE;
      end
      ST_SCALE: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == DIV_LAST) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_valid || sts.out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DIFF:      cmd.diff = 1'b1;
      ST_SQUARE:    cmd.square = 1'b1;
      ST_ROOT_INIT: cmd.root_init = 1'b1;
      ST_ROOT:      cmd.root_step = 1'b1;
      ST_ACCUM:     cmd.accum = 1'b1;
      ST_SCALE:     cmd.scale = 1'b1;
      ST_DIV:       cmd.div_step = 1'b1;
      ST_EMIT:      cmd.emit = !sts.out_valid || sts.out_ready;
      default: begin
        cmd      = '0;
        s_tready = 1'b0;
      end
    endcase
  end

  `ASSERT_CLK(a_emit_slot_free, cmd.emit |-> (!sts.out_valid || sts.out_ready), "result overwritten")
  `ASSERT_CLK(a_root_full, (state == ST_ACCUM) |-> ($past(cnt) == ROOT_LAST), "root cut short")
  `ASSERT_CLK(a_emit_on_last, (state == ST_EMIT) |-> sts.last, "result without last vertex")
  `ASSERT_NEVER(a_load_busy, cmd.load && (state != ST_IDLE), "request taken while busy")

endmodule

`default_nettype wire

### design/plt_datapath.sv
// datapath: vertex registers, root unit, length sum and scaling
`timescale 1ns / 1ps
`default_nettype none

module plt_datapath
  import plt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic [2*COORD_BITS-1:0] in_data,
  input  wire logic                  in_first,
  input  wire logic                  in_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_BITS-1:0]   cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_BITS-1:0]        out_data
);

  logic [COORD_BITS-1:0] x_in, y_in, prev_x, prev_y;
  logic                  first_r, last_r;
  logic [CFG_BITS-1:0]   repeat_count;
  logic [DIFF_BITS-1:0]  dx, dy;
  logic [SQ_BITS-1:0]    dxx, dyy;
  logic [RAD_BITS-1:0]   rad;
  logic [REM_BITS-1:0]   rem;
  logic [ROOT_BITS-1:0]  root;
  logic [SUM_BITS-1:0]   length_sum;
  logic [DIV_BITS-1:0]   prod;
  logic [DREM_BITS-1:0]  drem;

  logic [COORD_BITS:0]   dx_w, dy_w, dx_abs, dy_abs;
  logic [REM_BITS+1:0]   rem_sh, trial;
  logic [SUM_BITS:0]     sum_add;
  logic [DV_BITS-1:0]    dv, dr;
  logic [2*DV_BITS-1:0]  dprod;
  logic [DIV_DIGIT-1:0]  dq;

  assign cfg_ready = 1'b1;

  assign dx_w   = {x_in[COORD_BITS-1], x_in} - {prev_x[COORD_BITS-1], prev_x};
  assign dy_w   = {y_in[COORD_BITS-1], y_in} - {prev_y[COORD_BITS-1], prev_y};
  assign dx_abs = dx_w[COORD_BITS] ? (~dx_w + (COORD_BITS+1)'(1)) : dx_w;
  assign dy_abs = dy_w[COORD_BITS] ? (~dy_w + (COORD_BITS+1)'(1)) : dy_w;

  // one root digit per cycle
  assign rem_sh = {rem, rad[RAD_BITS-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  assign sum_add = {1'b0, length_sum} + (SUM_BITS+1)'(root);

  // one 8-bit quotient digit of the divide by fifty per cycle
  assign dv    = {drem, prod[DIV_BITS-1 -: DIV_DIGIT]};
  assign dprod = (2*DV_BITS)'(dv) * (2*DV_BITS)'(DIV_RECIP);
  assign dq    = dprod[DIV_SHIFT +: DIV_DIGIT];
  assign dr    = dv - DV_BITS'(dq) * DV_BITS'(SCALE_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count <= REPEAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      repeat_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x     <= '0;
      prev_y     <= '0;
      length_sum <= '0;
    end else begin
      if (cmd.diff) begin
        prev_x <= x_in;
        prev_y <= y_in;
        if (first_r) length_sum <= '0;
      end
      if (cmd.accum) begin
        length_sum <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
      end
      if (cmd.scale) length_sum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_in    <= in_data[COORD_BITS-1:0];
      y_in    <= in_data[2*COORD_BITS-1:COORD_BITS];
      first_r <= in_first;
      last_r  <= in_last;
    end
    if (cmd.diff) begin
      dx <= dx_abs[DIFF_BITS-1:0];
      dy <= dy_abs[DIFF_BITS-1:0];
    end
    if (cmd.square) begin
      dxx <= SQ_BITS'(dx) * SQ_BITS'(dx);
      dyy <= SQ_BITS'(dy) * SQ_BITS'(dy);
    end
    if (cmd.root_init) begin
      rad  <= RAD_BITS'(dxx) + RAD_BITS'(dyy);
      rem  <= '0;
      root <= '0;
    end
    if (cmd.root_step) begin
      rad <= {rad[RAD_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= REM_BITS'(rem_sh - trial);
        root <= {root[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[REM_BITS-1:0];
        root <= {root[ROOT_BITS-2:0], 1'b0};
      end
    end
    if (cmd.scale) begin
      prod <= DIV_BITS'(length_sum) * DIV_BITS'(repeat_count);
      drem <= '0;
    end
    if (cmd.div_step) begin
      drem <= dr[DREM_BITS-1:0];
      prod <= {prod[DIV_BITS-DIV_DIGIT-1:0], dq};
    end
    if (cmd.emit) out_data <= prod[OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.first     = first_r;
  assign sts.last      = last_r;
  assign sts.out_valid = out_valid;
  assign sts.out_ready = out_ready;

endmodule

`default_nettype wire

### design/polyline_length_time.sv
// polyline length block: top level joining controller and datapath
//
// Vertices arrive on the s_ stream, one per request: tdata holds coord_x in
// bits 15:0 and coord_y in bits 31:16, tuser is the first-point flag, tlast
// marks the last vertex. On a last vertex one 40-bit total_time goes out on
// the m_ stream: the summed segment lengths (8 fraction bits) times
// repeat_count, over 50, truncated. repeat_count is written through cfg_valid
// and cfg_data, taken in any cycle; write it only while the block is idle.
// One vertex is in work at a time. A vertex other than the first passes
// through the difference, squaring and the bit-serial square root, and its
// length is then added to the sum. A last vertex adds a scale multiply, the
// divide by 50 (one 8-bit quotient digit per cycle) and a load of the output
// register, which drives total_time on m_tdata with m_tvalid. The output register
// holds a result while the receiver stalls; the block keeps taking vertices
// and waits before its next result only if the earlier one is still unread.
// Reset clears the previous vertex to (0,0), the sum to zero, repeat_count
// to 1 and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module polyline_length_time
  import plt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [2*COORD_BITS-1:0] s_tdata,  // coord_x, coord_y
  input  wire logic                    s_tuser,  // first_point
  input  wire logic                    s_tlast,  // last_point
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [OUT_BITS-1:0]          m_tdata,  // total_time
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_BITS-1:0]     cfg_data  // repeat_count
);

  cmd_t cmd;
  sts_t sts;

  plt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .in_first  (s_tuser),
    .in_last   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire
